### rtl/core/ictl_pkg.sv
// Package for the injection controller: modes, commands, mode events, sequencer
// states, payload word types and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ictl_pkg;
   localparam int TablePoints = 8;
   localparam int PtW = $clog2(TablePoints);

   typedef enum logic [2:0] {
      MODE_FAIL = 3'd0, MODE_ARMED = 3'd1, MODE_INJ = 3'd2,
      MODE_DIS = 3'd3, MODE_WARN = 3'd4, MODE_LOW = 3'd5
   } mode_type;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_POLL    = 3'd1;
   localparam logic [2:0] CMD_FUEL    = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd4;
   localparam logic [2:0] CMD_LOAD    = 3'd6;

   // events applied to the mode machine
   localparam int EVT_DIS_ON  = 0;
   localparam int EVT_DIS_OFF = 1;
   localparam int EVT_ABOVE   = 2;
   localparam int EVT_BELOW   = 3;
   localparam int EVT_TANK    = 4;
   localparam int EVT_FAIL    = 6;

   localparam logic [1:0] REG_GAIN    = 2'd0;
   localparam logic [1:0] REG_LOWER   = 2'd1;
   localparam logic [1:0] REG_UPPER   = 2'd2;
   localparam logic [1:0] REG_TIMEOUT = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_CHECK,
      ST_SCAN, ST_MULS, ST_DIV, ST_FIX, ST_NEXT, ST_DONE
   } seq_type;

   typedef struct packed {
      logic [2:0]  command;
      logic        disable_active;
      logic        tank_empty;
      logic [15:0] fuel_raw;
      logic [1:0]  table_select;
      logic [2:0]  point_index;
      logic [15:0] point_value;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  mode_out;
      logic        pump_out;
      logic        failsafe_out;
      logic [7:0]  duty_out;
      logic        request_out;
      logic [15:0] fuel_rate_out;
   } rsp_word_type;
endpackage
`default_nettype wire

### rtl/core/injection_controller_fsm.sv
// Injection controller top level: mode machine plus a sequencer around one
// shared multiplier and one radix-2 divider. Depends on ictl_pkg.
//
// Usage: one request word (req_valid/req_stall) produces one response word
// (rsp_valid/rsp_stall). The block takes one word at a time; req_stall is
// high from acceptance until the response has been taken.
// Sequence: ticks, polls, aborts, restarts and table loads go from accept
// straight to the result. A fuel request always runs the multiply and the
// limit compare; while injecting, two table lookups follow, each a scan of
// up to TablePoints+1 positions with an optional interpolating multiply and
// divide, then a multiply and divide (to flow, then to the duty byte).
// Reset: mode failure, failsafe on, pump off, duty 0, tables zero, registers
// at their defaults. A stalled response is held and no new word is taken.
// Configuration (csr_) is to be written only while idle; the block itself
// does not enforce this. csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module injection_controller_fsm
   import ictl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   // configuration
   logic [31:0] gain_ff;
   logic [15:0] lower_ff, upper_ff;
   logic [7:0]  limit_ff;
   // controller state
   mode_type    mode_ff, mode_in;
   logic [7:0]  pend_ff, pend_in;
   logic        timer_ff, timer_in, pump_ff, pump_in, fs_ff, fs_in;
   logic [7:0]  duty_ff, duty_in;
   logic [15:0] tbl_ff [4][TablePoints];
   // sequencer
   seq_type     st_ff, st_in;
   logic [15:0] raw_ff;
   logic        rspv_ff;
   logic        req_ff, req_in;
   logic [15:0] rate_ff;
   logic [47:0] prod_ff;
   logic        lk_ff;            // 0: percent lookup, 1: duty lookup
   logic [PtW:0] idx_ff;
   logic [31:0] x_ff;
   logic [31:0] num_ff, quo_ff;
   logic [16:0] den_ff;
   logic [15:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic [1:0]  dk_ff;            // divide kind: 0 interp,1 flow,2 byte
   logic        neg_ff;
   logic [15:0] y0_ff;

   assign csr_ready = 1'b1;
   assign req_stall = (st_ff != ST_IDLE) || rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = '{mode_out: mode_ff, pump_out: pump_ff, failsafe_out: fs_ff,
                        duty_out: duty_ff, request_out: req_ff,
                        fuel_rate_out: rate_ff};

   logic accept;
   assign accept = req_valid && !req_stall;

   // shared multiplier, 32x16
   logic [31:0] ma;
   logic [15:0] mb;
   logic [47:0] mp;
   assign mp = {16'd0, ma} * {32'd0, mb};

   // table point under scan
   logic [1:0]  xsel;
   logic [PtW-1:0] ip, im;
   logic [15:0] xi, xm, yi, ym;
   assign xsel = lk_ff ? 2'd2 : 2'd0;
   assign ip = idx_ff[PtW-1:0];
   assign im = ip - 1'b1;
   assign xi = tbl_ff[xsel][ip];
   assign yi = tbl_ff[xsel+2'd1][ip];
   assign xm = tbl_ff[xsel][im];
   assign ym = tbl_ff[xsel+2'd1][im];

   always_comb begin
      ma = 32'd0;
      mb = 16'd0;
      case (st_ff)
         ST_MUL_LO: begin ma = gain_ff; mb = raw_ff; end
         ST_MULS: begin
            ma = neg_ff ? {16'd0, ym - yi} : {16'd0, yi - ym};
            mb = x_ff[15:0] - xm;
         end
         ST_FIX: begin ma = quo_ff; mb = lk_ff ? 16'd255 : rate_ff; end
         default: begin ma = 32'd0; mb = 16'd0; end
      endcase
   end

   // mode machine: apply one event
   function automatic void do_event(input int ev, inout mode_type m,
                                    inout logic pu, inout logic fs,
                                    inout logic tm, inout logic [7:0] du);
      if (ev == EVT_FAIL) begin
         pu = 1'b0; du = 8'd0; fs = 1'b1; tm = 1'b0; m = MODE_FAIL;
      end else if ((ev == EVT_DIS_ON &&
                    (m == MODE_ARMED || m == MODE_INJ || m == MODE_LOW))
                   || (ev == EVT_BELOW && m == MODE_WARN)) begin
         pu = 1'b0; du = 8'd0; fs = 1'b1; m = MODE_DIS;
      end else if (ev == EVT_TANK && (m == MODE_ARMED || m == MODE_INJ)) begin
         pu = 1'b0; du = 8'd0; fs = 1'b1; m = MODE_LOW;
      end else if ((ev == EVT_DIS_OFF && (m == MODE_DIS || m == MODE_WARN))
                   || (ev == EVT_BELOW && m == MODE_INJ)) begin
         pu = 1'b0; du = 8'd0; fs = 1'b0; m = MODE_ARMED;
      end else if (ev == EVT_ABOVE && m == MODE_ARMED) begin
         m = MODE_INJ;
      end else if (ev == EVT_ABOVE && m == MODE_DIS) begin
         m = MODE_WARN;
      end
   endfunction

   // next state of the sequencer
   logic below, above, hit;
   assign below = prod_ff < {lower_ff, 16'd0};
   assign above = prod_ff > {upper_ff, 16'd0};
   assign hit = (idx_ff == (PtW+1)'(TablePoints)) || (x_ff < {16'd0, xi});

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:   if (accept) st_in = (req_data.command == CMD_FUEL) ? ST_MUL_LO
                                                                     : ST_DONE;
         ST_MUL_LO: st_in = ST_MUL_HI;
         ST_MUL_HI: st_in = ST_CHECK;
         ST_CHECK:  st_in = (mode_in == MODE_INJ) ? ST_SCAN : ST_DONE;
         ST_SCAN: begin
            if (hit) begin
               if (idx_ff == '0 || idx_ff == (PtW+1)'(TablePoints) || xi == xm)
                  st_in = ST_NEXT;
               else st_in = ST_MULS;
            end
         end
         ST_MULS:   st_in = ST_DIV;
         ST_DIV: begin
            // interpolation goes on to ST_NEXT, flow starts the duty lookup, byte ends
            if (cnt_ff == 6'd0) begin
               case (dk_ff)
                  2'd0:    st_in = ST_NEXT;
                  2'd1:    st_in = ST_SCAN;
                  default: st_in = ST_DONE;
               endcase
            end
         end
         ST_NEXT:   st_in = ST_FIX;
         ST_FIX:    st_in = ST_DIV;
         ST_DONE:   if (!rsp_stall || !rspv_ff) st_in = rspv_ff ? ST_IDLE : ST_DONE;
         default:   st_in = ST_IDLE;
      endcase
   end

   // mode outputs on accept, after the fuel compare and after the duty divide
   always_comb begin
      mode_in = mode_ff; pend_in = pend_ff; timer_in = timer_ff;
      pump_in = pump_ff; fs_in = fs_ff; duty_in = duty_ff; req_in = req_ff;
      if (st_ff == ST_IDLE && accept) begin
         req_in = 1'b0;
         case (req_data.command)
            CMD_TICK: if (timer_ff) begin
               if (pend_ff >= limit_ff)
                  do_event(EVT_FAIL, mode_in, pump_in, fs_in, timer_in, duty_in);
               else begin
                  req_in = 1'b1;
                  if (pend_ff != 8'hFF) pend_in = pend_ff + 8'd1;
               end
            end
            CMD_POLL: begin
               do_event(req_data.disable_active ? EVT_DIS_ON : EVT_DIS_OFF, mode_in,
                        pump_in, fs_in, timer_in, duty_in);
               if (req_data.tank_empty)
                  do_event(EVT_TANK, mode_in, pump_in, fs_in, timer_in, duty_in);
            end
            CMD_FUEL: pend_in = 8'd0;
            CMD_RESTART: begin
               pump_in = 1'b0; duty_in = 8'd0; fs_in = 1'b0; timer_in = 1'b1;
               pend_in = 8'd0; mode_in = MODE_ARMED;
            end
            CMD_LOAD: ;
            default: do_event(EVT_FAIL, mode_in, pump_in, fs_in, timer_in, duty_in);
         endcase
      end else if (st_ff == ST_CHECK) begin
         if (below) do_event(EVT_BELOW, mode_in, pump_in, fs_in, timer_in, duty_in);
         if (above) do_event(EVT_ABOVE, mode_in, pump_in, fs_in, timer_in, duty_in);
      end else if (st_ff == ST_DIV && cnt_ff == 6'd0 && dk_ff == 2'd2) begin
         pump_in = 1'b1;
         duty_in = (quo_ff > 32'd255) ? 8'hFF : quo_ff[7:0];
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 32'd1496170; lower_ff <= 16'd100; upper_ff <= 16'd200;
         limit_ff <= 8'd3;
         mode_ff <= MODE_FAIL; pend_ff <= 8'd0; timer_ff <= 1'b0;
         pump_ff <= 1'b0; fs_ff <= 1'b1; duty_ff <= 8'd0;
         st_ff <= ST_IDLE; rspv_ff <= 1'b0; req_ff <= 1'b0; rate_ff <= 16'd0;
         for (int t = 0; t < 4; t++)
            for (int p = 0; p < TablePoints; p++) tbl_ff[t][p] <= 16'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAIN:    gain_ff  <= csr_data;
               REG_LOWER:   lower_ff <= csr_data[15:0];
               REG_UPPER:   upper_ff <= csr_data[15:0];
               REG_TIMEOUT: limit_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         st_ff <= st_in;
         mode_ff <= mode_in; pend_ff <= pend_in; timer_ff <= timer_in;
         pump_ff <= pump_in; fs_ff <= fs_in; duty_ff <= duty_in; req_ff <= req_in;
         if (st_ff == ST_DONE && !rspv_ff) rspv_ff <= 1'b1;
         else if (rspv_ff && !rsp_stall) rspv_ff <= 1'b0;
         if (accept) begin
            rate_ff <= 16'd0;
            if (req_data.command == CMD_LOAD &&
                {1'b0, req_data.point_index} < 4'(TablePoints))
               tbl_ff[req_data.table_select][PtW'(req_data.point_index)]
                  <= req_data.point_value;
         end
         if (st_ff == ST_MUL_HI)
            rate_ff <= (prod_ff[47:32] != 16'd0) ? 16'hFFFF : prod_ff[31:16];
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (accept) raw_ff <= req_data.fuel_raw;
      case (st_ff)
         ST_MUL_LO: prod_ff <= mp;
         ST_CHECK: begin
            lk_ff <= 1'b0; idx_ff <= '0; x_ff <= {16'd0, rate_ff};
         end
         ST_SCAN: if (!hit) idx_ff <= idx_ff + 1'b1;
         else begin
            neg_ff <= ym > yi;
            y0_ff <= (idx_ff == '0) ? tbl_ff[xsel+2'd1][0]
                   : (idx_ff == (PtW+1)'(TablePoints))
                     ? tbl_ff[xsel+2'd1][TablePoints-1] : ym;
            den_ff <= {1'b0, xi - xm};
         end
         ST_MULS: begin
            num_ff <= mp[31:0]; quo_ff <= 32'd0; rem_ff <= 16'd0;
            cnt_ff <= 6'd32; dk_ff <= 2'd0;
         end
         ST_DIV: begin
            // one restoring step per cycle
            if (cnt_ff != 6'd0) begin
               logic [16:0] tr;
               tr = {rem_ff, num_ff[31]};
               num_ff <= {num_ff[30:0], 1'b0};
               if (tr >= den_ff) begin
                  rem_ff <= 16'(tr - den_ff); quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= tr[15:0]; quo_ff <= {quo_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
            end else if (dk_ff == 2'd0) begin
               y0_ff <= neg_ff ? y0_ff - quo_ff[15:0] : y0_ff + quo_ff[15:0];
            end else if (dk_ff == 2'd1) begin
               // flow ready: start duty lookup
               lk_ff <= 1'b1; idx_ff <= '0; x_ff <= quo_ff;
            end
         end
         ST_NEXT: quo_ff <= {16'd0, y0_ff};
         ST_FIX: begin
            num_ff <= mp[31:0]; rem_ff <= 16'd0; quo_ff <= 32'd0;
            den_ff <= 17'd10000; cnt_ff <= 6'd32; dk_ff <= lk_ff ? 2'd2 : 2'd1;
         end
         default: ;
      endcase
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> req_stall) else $error("taken while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (rspv_ff && !rsp_stall) |=> !rspv_ff) else $error("response repeated");
   a_fail_fs: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_FAIL) |-> (fs_ff && !pump_ff)) else $error("fail drives");
   a_pump_inj: assert property (@(posedge clock) disable iff (reset)
      pump_ff |-> (mode_ff == MODE_INJ)) else $error("pump outside injecting");
endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the injection controller: drives request words,
// predicts each response word and compares. Depends on ictl_pkg and the block.
`timescale 1ns / 1ps
module tb_top;
   import ictl_pkg::*;

   localparam logic [2:0] CMD_ABORT   = 3'd3;
   localparam logic [2:0] CMD_POWERUP = 3'd5;
   localparam logic [2:0] CMD_SPARE   = 3'd7;

   typedef enum int {
      EV_DIS_ON, EV_DIS_OFF, EV_ABOVE, EV_BELOW, EV_TANK, EV_MSG, EV_FAIL, EV_RESTART
   } mode_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   injection_controller_fsm DUT (.*);

   always #5 clock = ~clock;

   // predicted controller state and registers
   logic [31:0] gain_q16;
   logic [15:0] low_limit, high_limit;
   logic [7:0] max_pending;
   mode_type mode_q;
   logic [7:0] pending_q;
   logic timer_on_q, pump_q, failsafe_q;
   logic [7:0] duty_q;
   logic [15:0] curve [4][TablePoints];

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int mismatches = 0, words_checked = 0, words_sent = 0, config_writes = 0;
   int hold_left = 0;
   bit hold_done = 0;

   function automatic logic [31:0] interpolate(logic [31:0] x, x0, x1, y0, y1);
      logic [63:0] span, off;
      span = x1 - x0;
      off = x - x0;
      if (span == 0) return y0;
      if (y1 >= y0) return y0 + 32'(((y1 - y0) * off) / span);
      return y0 - 32'(((y0 - y1) * off) / span);
   endfunction

   function automatic logic [31:0] curve_lookup(int xt, int yt, logic [31:0] x);
      int i;
      for (i = 0; i < TablePoints; i++)
         if (x < curve[xt][i]) break;
      if (i == TablePoints) return curve[yt][TablePoints-1];
      if (i == 0) return curve[yt][0];
      return interpolate(x, curve[xt][i-1], curve[xt][i], curve[yt][i-1], curve[yt][i]);
   endfunction

   function automatic void stop_pump();
      pump_q = 1'b0;
      duty_q = '0;
   endfunction

   function automatic void apply_event(mode_event_type ev, logic [31:0] rate);
      logic [31:0] pct, flow, duty;
      logic [63:0] b;
      if (ev == EV_RESTART) begin
         stop_pump();
         failsafe_q = 1'b0;
         timer_on_q = 1'b1;
         pending_q = '0;
         mode_q = MODE_ARMED;
      end else if (ev == EV_FAIL) begin
         stop_pump();
         failsafe_q = 1'b1;
         timer_on_q = 1'b0;
         mode_q = MODE_FAIL;
      end else if ((ev == EV_DIS_ON && mode_q inside {MODE_ARMED, MODE_INJ, MODE_LOW}) ||
                   (ev == EV_BELOW && mode_q == MODE_WARN)) begin
         stop_pump();
         failsafe_q = 1'b1;
         mode_q = MODE_DIS;
      end else if (ev == EV_TANK && mode_q inside {MODE_ARMED, MODE_INJ}) begin
         stop_pump();
         failsafe_q = 1'b1;
         mode_q = MODE_LOW;
      end else if ((ev == EV_DIS_OFF && mode_q inside {MODE_DIS, MODE_WARN}) ||
                   (ev == EV_BELOW && mode_q == MODE_INJ)) begin
         stop_pump();
         failsafe_q = 1'b0;
         mode_q = MODE_ARMED;
      end else if (ev == EV_ABOVE && mode_q == MODE_ARMED) begin
         mode_q = MODE_INJ;
      end else if (ev == EV_ABOVE && mode_q == MODE_DIS) begin
         mode_q = MODE_WARN;
      end else if (ev == EV_MSG && mode_q == MODE_INJ) begin
         pct = curve_lookup(0, 1, rate);
         flow = 32'((64'(pct) * rate) / 10000);
         duty = curve_lookup(2, 3, flow);
         b = (64'(duty) * 255) / 10000;
         pump_q = 1'b1;
         duty_q = (b > 255) ? 8'hFF : b[7:0];
      end
   endfunction

   // advance the predicted state by one request word, return its response
   function automatic rsp_word_type predict_response(req_word_type w);
      rsp_word_type r;
      logic [63:0] p;
      r = '0;
      case (w.command)
         CMD_TICK: if (timer_on_q) begin
            if (pending_q >= max_pending) apply_event(EV_FAIL, 0);
            else begin
               r.request_out = 1'b1;
               if (pending_q < 8'hFF) pending_q++;
            end
         end
         CMD_POLL: begin
            apply_event(w.disable_active ? EV_DIS_ON : EV_DIS_OFF, 0);
            if (w.tank_empty) apply_event(EV_TANK, 0);
         end
         CMD_FUEL: begin
            p = 64'(w.fuel_raw) * gain_q16;
            r.fuel_rate_out = (p[63:16] > 48'hFFFF) ? 16'hFFFF : p[31:16];
            if (p < {32'd0, low_limit, 16'd0}) apply_event(EV_BELOW, r.fuel_rate_out);
            if (p > {32'd0, high_limit, 16'd0}) apply_event(EV_ABOVE, r.fuel_rate_out);
            apply_event(EV_MSG, r.fuel_rate_out);
            pending_q = '0;
         end
         CMD_RESTART: apply_event(EV_RESTART, 0);
         CMD_LOAD: curve[w.table_select][w.point_index] = w.point_value;
         default: apply_event(EV_FAIL, 0);
      endcase
      r.mode_out = mode_q;
      r.pump_out = pump_q;
      r.failsafe_out = failsafe_q;
      r.duty_out = duty_q;
      return r;
   endfunction

   // sender: hold a stalled word, predict on acceptance, then offer the next
   always @(posedge clock) begin
      logic next_valid;
      req_word_type next_data;
      next_valid = req_valid;
      next_data = req_data;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_words.push_back(predict_response(req_data));
            words_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_words.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_data = pending_words.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_data <= next_data;
   end

   // receiver: random stall, plus one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && words_checked == 500) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // compare each taken response word with the oldest prediction
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_data);
         end else begin
            exp_w = expected_words.pop_front();
            words_checked++;
            if (rsp_data.mode_out !== exp_w.mode_out || rsp_data.pump_out !== exp_w.pump_out ||
                rsp_data.failsafe_out !== exp_w.failsafe_out ||
                rsp_data.duty_out !== exp_w.duty_out ||
                rsp_data.request_out !== exp_w.request_out ||
                rsp_data.fuel_rate_out !== exp_w.fuel_rate_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: expected mode %0d pump %b fs %b duty %0d req %b rate %0d, got mode %0d pump %b fs %b duty %0d req %b rate %0d",
                           words_checked, exp_w.mode_out, exp_w.pump_out, exp_w.failsafe_out,
                           exp_w.duty_out, exp_w.request_out, exp_w.fuel_rate_out,
                           rsp_data.mode_out, rsp_data.pump_out, rsp_data.failsafe_out,
                           rsp_data.duty_out, rsp_data.request_out, rsp_data.fuel_rate_out);
            end
         end
      end
   end

   function automatic req_word_type make_word(logic [2:0] cmd);
      req_word_type w;
      w = '0;
      w.command = cmd;
      w.disable_active = 1'($urandom);
      w.tank_empty = 1'($urandom);
      w.fuel_raw = 16'($urandom);
      w.table_select = 2'($urandom);
      w.point_index = 3'($urandom);
      w.point_value = 16'($urandom);
      return w;
   endfunction

   function automatic void queue_word(logic [2:0] cmd, logic [15:0] raw, logic dis, logic tank);
      req_word_type w;
      w = make_word(cmd);
      w.fuel_raw = raw;
      w.disable_active = dis;
      w.tank_empty = tank;
      pending_words.push_back(w);
   endfunction

   function automatic void queue_point(int sel, int idx, logic [15:0] v);
      req_word_type w;
      w = make_word(CMD_LOAD);
      w.table_select = 2'(sel);
      w.point_index = 3'(idx);
      w.point_value = v;
      pending_words.push_back(w);
   endfunction

   // mostly well-formed runs: restart, clean poll, fuel words around the bounds
   function automatic void queue_random(int count);
      int k, roll;
      logic [15:0] raw;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         raw = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
         if (roll < 5) queue_word(CMD_RESTART, raw, 0, 0);
         else if (roll < 15) queue_word(CMD_POLL, raw, $urandom_range(4) == 0,
                                        $urandom_range(7) == 0);
         else if (roll < 55) queue_word(CMD_FUEL, raw, 1'($urandom), 1'($urandom));
         else if (roll < 80) queue_word(CMD_TICK, raw, 1'($urandom), 1'($urandom));
         else if (roll < 90) pending_words.push_back(make_word(CMD_LOAD));
         else if (roll < 93) pending_words.push_back(make_word(3'($urandom)));
         else begin
            queue_word(CMD_RESTART, raw, 0, 0);
            queue_word(CMD_POLL, raw, 0, 0);
         end
      end
   endfunction

   // offer one register word and hold it until taken; the caller drops valid
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GAIN: gain_q16 = value;
         REG_LOWER: low_limit = value[15:0];
         REG_UPPER: high_limit = value[15:0];
         REG_TIMEOUT: max_pending = value[7:0];
         default: ;
      endcase
      config_writes++;
   endtask

   // drain the block, then let the longest fuel sequence finish
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] g, logic [15:0] lo, logic [15:0] hi, logic [7:0] t);
      write_reg(REG_GAIN, g);
      write_reg(REG_LOWER, lo);
      write_reg(REG_UPPER, hi);
      write_reg(REG_TIMEOUT, t);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int i;
      gain_q16 = 32'd1496170;
      low_limit = 16'd100;
      high_limit = 16'd200;
      max_pending = 8'd3;
      mode_q = MODE_FAIL;
      pending_q = '0;
      timer_on_q = 1'b0;
      pump_q = 1'b0;
      failsafe_q = 1'b1;
      duty_q = '0;
      foreach (curve[s, p]) curve[s][p] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: sorted curves, arm, inject, timeout, odd commands
      for (i = 0; i < TablePoints; i++) begin
         queue_point(0, i, 16'(100 + i * 300));
         queue_point(2, i, 16'(20 + i * 40));
      end
      queue_point(1, 0, 16'd1000);
      queue_point(3, 7, 16'hFFFF);
      queue_word(CMD_FUEL, 16'd50, 0, 0);
      queue_word(CMD_RESTART, 0, 0, 0);
      queue_word(CMD_POLL, 0, 0, 0);
      queue_word(CMD_FUEL, 16'd12, 0, 0);
      queue_word(CMD_FUEL, 16'd30, 0, 0);
      queue_word(CMD_FUEL, 16'hFFFF, 1, 1);
      queue_word(CMD_TICK, 0, 0, 0);
      for (i = 0; i < 4; i++) queue_word(CMD_TICK, 16'hFFFF, 1, 1);
      queue_word(CMD_TICK, 0, 0, 0);
      queue_word(CMD_RESTART, 0, 0, 0);
      queue_word(CMD_POLL, 0, 1, 0);
      queue_word(CMD_FUEL, 16'd20, 0, 0);
      queue_word(CMD_FUEL, 16'd1, 0, 0);
      queue_word(CMD_POLL, 0, 0, 1);
      queue_word(CMD_ABORT, 0, 0, 0);
      queue_word(CMD_POWERUP, 0, 0, 0);
      queue_word(CMD_SPARE, 0, 0, 0);
      send_idle_pct = 20;
      recv_idle_pct = 88;
      wait_idle();

      write_all(32'd1496170, 16'd100, 16'd200, 8'd3);
      queue_random(350);
      wait_idle();

      write_all(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 8'd1);
      send_idle_pct = 88;
      recv_idle_pct = 20;
      queue_random(150);
      wait_idle();

      write_all(32'd0, 16'hFFFF, 16'd0, 8'd255);
      queue_random(50);
      wait_idle();

      write_all(32'd3000000, 16'd150, 16'd300, 8'd8);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(460);
      wait_idle();

      $display("ran %0d request words, checked %0d responses, %0d register writes",
               words_sent, words_checked, config_writes);
      if (mismatches == 0 && expected_words.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d responses outstanding", expected_words.size());
      $display("CHECK FAILED");
      $finish;
   end
endmodule
